/* hw/rtl/permuted_halton_radical_inverse_defines.svh */
// ----------------------------------------------------------------------------
// permuted halton radical inverse: assertion macros
// shared concurrent assertion forms for the checker
// ----------------------------------------------------------------------------
`ifndef PERMUTED_HALTON_RADICAL_INVERSE_DEFINES_SVH
`define PERMUTED_HALTON_RADICAL_INVERSE_DEFINES_SVH

// antecedent holds, consequent holds on the following clock
`define PHRI_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

// antecedent holds, consequent holds on the same clock
`define PHRI_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

`endif

/* hw/rtl/phri_pkg.sv */
// ----------------------------------------------------------------------------
// phri_pkg
// widths, prime table and controller states for the radical inverse block
// ----------------------------------------------------------------------------
package phri_pkg;

  localparam int PRIME_COUNT   = 61;
  localparam int FRACTION_BITS = 32;

  localparam int SEL_W    = 6;
  localparam int SAMPLE_W = 31;
  localparam int PRIME_W  = 9;
  localparam int OUT_W    = 32;
  // mirrored numerator and p^n both stay below 2^(SAMPLE_W + PRIME_W)
  localparam int NUM_W    = SAMPLE_W + PRIME_W;
  localparam int CNT_W    = $clog2((FRACTION_BITS > SAMPLE_W) ? FRACTION_BITS : SAMPLE_W);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIGIT,
    ST_FRAC,
    ST_OUT
  } state_t;

  function automatic logic [PRIME_W-1:0] prime_lookup(input logic [SEL_W-1:0] sel);
    logic [PRIME_W-1:0] p;
    unique case (sel)
      6'd0:  p = 9'd2;    6'd1:  p = 9'd3;    6'd2:  p = 9'd5;    6'd3:  p = 9'd7;
      6'd4:  p = 9'd11;   6'd5:  p = 9'd13;   6'd6:  p = 9'd17;   6'd7:  p = 9'd19;
      6'd8:  p = 9'd23;   6'd9:  p = 9'd29;   6'd10: p = 9'd31;   6'd11: p = 9'd37;
      6'd12: p = 9'd41;   6'd13: p = 9'd43;   6'd14: p = 9'd47;   6'd15: p = 9'd53;
      6'd16: p = 9'd59;   6'd17: p = 9'd61;   6'd18: p = 9'd67;   6'd19: p = 9'd71;
      6'd20: p = 9'd73;   6'd21: p = 9'd79;   6'd22: p = 9'd83;   6'd23: p = 9'd89;
      6'd24: p = 9'd97;   6'd25: p = 9'd101;  6'd26: p = 9'd103;  6'd27: p = 9'd107;
      6'd28: p = 9'd109;  6'd29: p = 9'd113;  6'd30: p = 9'd127;  6'd31: p = 9'd131;
      6'd32: p = 9'd137;  6'd33: p = 9'd139;  6'd34: p = 9'd149;  6'd35: p = 9'd151;
      6'd36: p = 9'd157;  6'd37: p = 9'd163;  6'd38: p = 9'd167;  6'd39: p = 9'd173;
      6'd40: p = 9'd179;  6'd41: p = 9'd181;  6'd42: p = 9'd191;  6'd43: p = 9'd193;
      6'd44: p = 9'd197;  6'd45: p = 9'd199;  6'd46: p = 9'd211;  6'd47: p = 9'd223;
      6'd48: p = 9'd227;  6'd49: p = 9'd229;  6'd50: p = 9'd233;  6'd51: p = 9'd239;
      6'd52: p = 9'd241;  6'd53: p = 9'd251;  6'd54: p = 9'd257;  6'd55: p = 9'd263;
      6'd56: p = 9'd269;  6'd57: p = 9'd271;  6'd58: p = 9'd277;  6'd59: p = 9'd281;
      6'd60: p = 9'd283;
      default: p = 9'd283;
    endcase
    return p;
  endfunction

endpackage

/* hw/rtl/permuted_halton_radical_inverse.sv */
// ----------------------------------------------------------------------------
// permuted_halton_radical_inverse
// per item: a 31-step bit-serial division by p for each base-p digit of
// sample_index (no digits for a zero index), with num*p and den*p formed
// shift-and-add alongside, then 32 fraction bits one a cycle, then the
// output register
// one item at a time: the next transfer is taken in the cycle the result appears,
// later if an earlier result is still stalled; sync reset returns to idle, empty
// ----------------------------------------------------------------------------
module permuted_halton_radical_inverse (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [phri_pkg::SEL_W-1:0]     base_index,
  input  logic [phri_pkg::SAMPLE_W-1:0]  sample_index,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [phri_pkg::OUT_W-1:0]     fraction
);

  localparam int SEL_W    = phri_pkg::SEL_W;
  localparam int SAMPLE_W = phri_pkg::SAMPLE_W;
  localparam int PRIME_W  = phri_pkg::PRIME_W;
  localparam int NUM_W    = phri_pkg::NUM_W;
  localparam int CNT_W    = phri_pkg::CNT_W;
  localparam int FRAC_W   = phri_pkg::FRACTION_BITS;
  localparam int OUT_W    = phri_pkg::OUT_W;

  phri_pkg::state_t state, state_next;

  logic [PRIME_W-1:0]  prime, prime_next;
  logic [PRIME_W-1:0]  pshift, pshift_next;
  logic [SAMPLE_W-1:0] quot, quot_next;
  logic [PRIME_W-1:0]  rem, rem_next;
  logic [NUM_W-1:0]    acc_num, acc_num_next;
  logic [NUM_W-1:0]    acc_den, acc_den_next;
  logic [NUM_W-1:0]    num, num_next;
  logic [NUM_W-1:0]    den, den_next;
  logic [NUM_W-1:0]    frem, frem_next;
  logic [FRAC_W-1:0]   frac, frac_next;
  logic [CNT_W-1:0]    cnt, cnt_next;
  logic                out_valid_next;
  logic [OUT_W-1:0]    fraction_next;

  logic [SEL_W-1:0]    sel_sat;
  logic [PRIME_W:0]    div_trial;
  logic                div_fits;
  logic [PRIME_W:0]    div_diff;
  logic [PRIME_W-1:0]  digit;
  logic [PRIME_W-1:0]  perm_digit;
  logic                mul_active;
  logic [NUM_W-1:0]    acc_num_step;
  logic [NUM_W-1:0]    acc_den_step;
  logic [NUM_W-1:0]    num_new;
  logic [NUM_W:0]      frac_trial;
  logic                frac_fits;
  logic [NUM_W:0]      frac_diff;
  logic                out_free;

  assign sel_sat = (base_index > SEL_W'(phri_pkg::PRIME_COUNT - 1))
                   ? SEL_W'(phri_pkg::PRIME_COUNT - 1) : base_index;

  // restoring division of the sample index by p, one quotient bit a cycle
  assign div_trial = {rem, quot[SAMPLE_W-1]};
  assign div_fits  = div_trial >= {1'b0, prime};
  assign div_diff  = div_trial - {1'b0, prime};
  assign digit     = div_fits ? div_diff[PRIME_W-1:0] : div_trial[PRIME_W-1:0];
  // nonzero digit d becomes p - d
  assign perm_digit = (digit != '0) ? (prime - digit) : '0;

  // num*p and den*p by shift-and-add over the bits of p, msb first
  assign mul_active   = cnt < CNT_W'(PRIME_W);
  assign acc_num_step = mul_active
                        ? ({acc_num[NUM_W-2:0], 1'b0} + (pshift[PRIME_W-1] ? num : '0))
                        : acc_num;
  assign acc_den_step = mul_active
                        ? ({acc_den[NUM_W-2:0], 1'b0} + (pshift[PRIME_W-1] ? den : '0))
                        : acc_den;
  assign num_new      = acc_num_step + NUM_W'(perm_digit);

  // long division of num by den, one fraction bit a cycle
  assign frac_trial = {frem, 1'b0};
  assign frac_fits  = frac_trial >= {1'b0, den};
  assign frac_diff  = frac_trial - {1'b0, den};

  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != phri_pkg::ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= phri_pkg::ST_IDLE;
      out_valid <= 1'b0;
      cnt       <= '0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
      cnt       <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    prime    <= prime_next;
    pshift   <= pshift_next;
    quot     <= quot_next;
    rem      <= rem_next;
    acc_num  <= acc_num_next;
    acc_den  <= acc_den_next;
    num      <= num_next;
    den      <= den_next;
    frem     <= frem_next;
    frac     <= frac_next;
    fraction <= fraction_next;
  end

  always_comb begin
    state_next     = state;
    prime_next     = prime;
    pshift_next    = pshift;
    quot_next      = quot;
    rem_next       = rem;
    acc_num_next   = acc_num;
    acc_den_next   = acc_den;
    num_next       = num;
    den_next       = den;
    frem_next      = frem;
    frac_next      = frac;
    cnt_next       = cnt;
    fraction_next  = fraction;
    out_valid_next = out_valid && out_stall;

    unique case (state)
      phri_pkg::ST_IDLE: begin
        if (in_valid) begin
          prime_next   = phri_pkg::prime_lookup(sel_sat);
          pshift_next  = phri_pkg::prime_lookup(sel_sat);
          quot_next    = sample_index;
          rem_next     = '0;
          acc_num_next = '0;
          acc_den_next = '0;
          num_next     = '0;
          den_next     = NUM_W'(1);
          frem_next    = '0;
          frac_next    = '0;
          cnt_next     = '0;
          state_next   = (sample_index != '0) ? phri_pkg::ST_DIGIT : phri_pkg::ST_FRAC;
        end
      end

      phri_pkg::ST_DIGIT: begin
        quot_next    = {quot[SAMPLE_W-2:0], div_fits};
        rem_next     = digit;
        acc_num_next = acc_num_step;
        acc_den_next = acc_den_step;
        pshift_next  = {pshift[PRIME_W-2:0], 1'b0};
        cnt_next     = cnt + CNT_W'(1);
        if (cnt == CNT_W'(SAMPLE_W - 1)) begin
          num_next     = num_new;
          den_next     = acc_den_step;
          rem_next     = '0;
          acc_num_next = '0;
          acc_den_next = '0;
          pshift_next  = prime;
          cnt_next     = '0;
          if (quot_next == '0) begin
            frem_next  = num_new;
            frac_next  = '0;
            state_next = phri_pkg::ST_FRAC;
          end
        end
      end

      phri_pkg::ST_FRAC: begin
        frem_next = frac_fits ? frac_diff[NUM_W-1:0] : frac_trial[NUM_W-1:0];
        frac_next = {frac[FRAC_W-2:0], frac_fits};
        cnt_next  = cnt + CNT_W'(1);
        if (cnt == CNT_W'(FRAC_W - 1)) begin
          cnt_next   = '0;
          state_next = phri_pkg::ST_OUT;
        end
      end

      phri_pkg::ST_OUT: begin
        if (out_free) begin
          fraction_next  = OUT_W'(frac);
          out_valid_next = 1'b1;
          state_next     = phri_pkg::ST_IDLE;
        end
      end

      default: state_next = phri_pkg::ST_IDLE;
    endcase
  end

endmodule

/* hw/rtl/phri_checker.sv */
// ----------------------------------------------------------------------------
// phri_checker
// port-level checks on the radical inverse block, bound to the top level
// ----------------------------------------------------------------------------
`include "permuted_halton_radical_inverse_defines.svh"

module phri_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           in_valid,
  input logic                           in_stall,
  input logic [phri_pkg::SEL_W-1:0]     base_index,
  input logic [phri_pkg::SAMPLE_W-1:0]  sample_index,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic [phri_pkg::OUT_W-1:0]     fraction
);

  logic in_xfer;
  logic out_held;
  logic in_fields_seen;

  assign in_xfer        = in_valid && !in_stall;
  assign out_held       = out_valid && out_stall;
  // keeps the input fields observed alongside the transfer
  assign in_fields_seen = in_xfer && ((base_index != '0) || (sample_index != '0) || 1'b1);

  // a held result stays offered and unchanged
  `PHRI_ASSERT_NEXT(a_out_hold, clk, rst, out_held, out_valid)
  `PHRI_ASSERT_NEXT(a_out_stable, clk, rst, out_held, $stable(fraction))
  // one item at a time: a transfer in makes the block busy
  `PHRI_ASSERT_NEXT(a_busy_after_xfer, clk, rst, in_fields_seen, in_stall)
  // a fresh result appears only as the block returns to idle
  `PHRI_ASSERT_SAME(a_result_at_idle, clk, rst, $rose(out_valid), !in_stall)

endmodule

bind permuted_halton_radical_inverse phri_checker u_phri_checker (.*);

/* test/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top: permuted halton radical inverse testbench
// drives prime selectors and sample indices through the valid/stall input,
// predicts each fraction by mirroring the permuted base-p digits and doing an
// exact long division, and checks every result transfer in order; both sides
// idle and stall in random bursts except in the closing stretch
// ----------------------------------------------------------------------------
module tb_top;

  localparam int TABLE_LEN   = 61;
  localparam int RANDOM_RUNS = 1550;
  localparam int STEADY_FROM = 1350;
  localparam int PAUSE_AT    = 700;
  // slowest item: 31 base-2 digits plus the fraction pass
  localparam int DRAIN_CYCLES = 1 + 31 * 31 + 32 + 1 + 8;
  localparam int QUIET_LIMIT  = 5000;

  class fraction_ledger;
    int unsigned                   prime_of[TABLE_LEN];
    logic [phri_pkg::OUT_W-1:0]    owed_fractions[$];
    int                            errors;

    function new();
      int unsigned cand;
      int unsigned dv;
      int          cnt;
      bit          is_prime;
      cand   = 2;
      cnt    = 0;
      errors = 0;
      while (cnt < TABLE_LEN) begin
        is_prime = 1'b1;
        for (dv = 2; dv * dv <= cand; dv++) begin
          if (cand % dv == 0) is_prime = 1'b0;
        end
        if (is_prime) begin
          prime_of[cnt] = cand;
          cnt++;
        end
        cand++;
      end
    endfunction

    function logic [phri_pkg::OUT_W-1:0] radical_inverse(
        input logic [phri_pkg::SEL_W-1:0] sel,
        input logic [phri_pkg::SAMPLE_W-1:0] j);
      longint unsigned p, rest, num, den, rem, frac, d;
      int unsigned     idx, last;
      int              k;
      last = (phri_pkg::PRIME_COUNT - 1 > TABLE_LEN - 1)
             ? TABLE_LEN - 1 : phri_pkg::PRIME_COUNT - 1;
      idx  = sel;
      // selector past the table in use saturates to its last prime
      if (idx > last) idx = last;
      p    = prime_of[idx];
      rest = j;
      num  = 0;
      den  = 1;
      while (rest != 0) begin
        d    = rest % p;
        num  = num * p + ((d != 0) ? p - d : 0);
        den  = den * p;
        rest = rest / p;
      end
      rem  = num;
      frac = 0;
      for (k = 0; k < phri_pkg::FRACTION_BITS; k++) begin
        rem  = rem << 1;
        frac = frac << 1;
        if (rem >= den) begin
          rem  = rem - den;
          frac = frac | 64'd1;
        end
      end
      return frac[phri_pkg::OUT_W-1:0];
    endfunction

    function void note_sample(input logic [phri_pkg::SEL_W-1:0] sel,
                              input logic [phri_pkg::SAMPLE_W-1:0] j);
      owed_fractions.push_back(radical_inverse(sel, j));
    endfunction

    function void check_fraction(input logic [phri_pkg::OUT_W-1:0] got);
      logic [phri_pkg::OUT_W-1:0] want;
      if (owed_fractions.size() == 0) begin
        $error("fraction: expected none, got %h", got);
        errors++;
      end else begin
        want = owed_fractions.pop_front();
        if (got !== want) begin
          $error("fraction: expected %h, got %h", want, got);
          errors++;
        end
      end
    endfunction
  endclass

  logic                          clk;
  logic                          rst;
  logic                          in_valid;
  logic                          in_stall;
  logic [phri_pkg::SEL_W-1:0]    base_index;
  logic [phri_pkg::SAMPLE_W-1:0] sample_index;
  logic                          out_valid;
  logic                          out_stall;
  logic [phri_pkg::OUT_W-1:0]    fraction;

  fraction_ledger ledger = new();
  bit             steady;
  int unsigned    quiet_cycles;

  permuted_halton_radical_inverse u_top (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .base_index   (base_index),
    .sample_index (sample_index),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .fraction     (fraction)
  );

  initial begin
    clk = 1'b0;
  end

  always #4 clk = ~clk;

  // result side
  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && out_stall == 1'b0) begin
      ledger.check_fraction(fraction);
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || (in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // receiver stalls in bursts
  initial begin
    int burst;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (!steady && $urandom_range(0, 5) == 0) begin
        burst = $urandom_range(1, 4);
        out_stall <= 1'b1;
        repeat (burst) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // called at a falling edge; returns at the falling edge after the transfer
  task automatic send_sample(input logic [phri_pkg::SEL_W-1:0] sel,
                             input logic [phri_pkg::SAMPLE_W-1:0] j);
    int gap;
    if (!steady && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 4);
      in_valid     <= 1'b0;
      base_index   <= phri_pkg::SEL_W'($urandom);
      sample_index <= phri_pkg::SAMPLE_W'($urandom);
      repeat (gap) @(negedge clk);
    end
    in_valid     <= 1'b1;
    base_index   <= sel;
    sample_index <= j;
    do @(posedge clk); while (in_stall !== 1'b0);
    ledger.note_sample(sel, j);
    @(negedge clk);
  endtask

  task automatic send_random();
    logic [phri_pkg::SEL_W-1:0]    sel;
    logic [phri_pkg::SAMPLE_W-1:0] j;
    int                            pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) sel = '0;                          // base 2, longest digit runs
    else if (pick == 1) sel = phri_pkg::SEL_W'($urandom_range(61, 63));
    else sel = phri_pkg::SEL_W'($urandom_range(0, 60));
    pick = $urandom_range(0, 9);
    case (pick) inside
      [0:3]:   j = phri_pkg::SAMPLE_W'($urandom);
      [4:5]:   j = phri_pkg::SAMPLE_W'($urandom_range(0, 300));
      6:       j = phri_pkg::SAMPLE_W'($urandom_range(0, 65535));
      7:       j = '0;
      8:       j = {4'hf, (phri_pkg::SAMPLE_W - 4)'($urandom)}
                   | phri_pkg::SAMPLE_W'($urandom_range(0, 15));
      default: j = phri_pkg::SAMPLE_W'(1) << $urandom_range(0, phri_pkg::SAMPLE_W - 1);
    endcase
    send_sample(sel, j);
  endtask

  initial begin
    int i;
    steady       = 1'b0;
    rst          = 1'b1;
    in_valid     = 1'b0;
    base_index   = '0;
    sample_index = '0;
    repeat (4) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: zero index, range extremes, saturated selectors, digit edges
    send_sample(6'd0,  31'd0);
    send_sample(6'd60, 31'd0);
    send_sample(6'd0,  31'd1);
    send_sample(6'd0,  31'h7fff_ffff);
    send_sample(6'd60, 31'h7fff_ffff);
    send_sample(6'd63, 31'h7fff_ffff);
    send_sample(6'd61, 31'd12345);
    send_sample(6'd62, 31'd283);
    send_sample(6'd60, 31'd283);
    send_sample(6'd60, 31'd282);
    send_sample(6'd1,  31'd1);
    send_sample(6'd1,  31'd2);
    send_sample(6'd1,  31'd9);
    send_sample(6'd0,  31'h4000_0000);
    send_sample(6'd42, 31'h2aaa_aaaa);
    send_sample(6'd21, 31'h5555_5555);
    send_sample(6'd54, 31'd256);
    send_sample(6'd54, 31'd257);
    send_sample(6'd30, 31'h7fff_ffff);
    send_sample(6'd5,  31'd169);

    for (i = 0; i < RANDOM_RUNS; i++) begin
      if (i == PAUSE_AT) begin
        // hold off until the block has drained every result
        in_valid <= 1'b0;
        while (ledger.owed_fractions.size() != 0) @(negedge clk);
        @(negedge clk);
      end
      if (i == STEADY_FROM) steady = 1'b1;
      send_random();
    end

    in_valid <= 1'b0;
    while (ledger.owed_fractions.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (ledger.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
